// File: sv/assert_macros.svh
// assertion macros shared by the substring matcher rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define SSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define SSM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: sv/ssm_pkg.sv
// constants, types and helper functions of the substring matcher
`timescale 1ns / 1ps
package ssm_pkg;

    localparam int PATTERN_MAX = 8;
    localparam int POS_BITS    = 16;
    localparam int CHAR_BITS   = 8;
    localparam int PAT_BITS    = 64;
    localparam int LEN_BITS    = 4;
    localparam int OUT_BITS    = 16;
    localparam int PAT_SEL_W   = $clog2(PAT_BITS / CHAR_BITS);
    localparam int CALC_W      = ((POS_BITS > OUT_BITS) ? POS_BITS : OUT_BITS) + 1;
    localparam int RES_BITS    = 1 + 3 * OUT_BITS + 1;
    localparam int TDATA_W     = ((RES_BITS + 7) / 8) * 8;
    localparam int TDATA_PAD   = TDATA_W - RES_BITS;
    localparam int IN_TDATA_W  = ((CHAR_BITS + 7) / 8) * 8;

    localparam logic [POS_BITS-1:0] POS_LIMIT = {POS_BITS{1'b1}};
    localparam logic [OUT_BITS-1:0] COUNT_MAX = {OUT_BITS{1'b1}};

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_PATTERN = 1'b0,
        CFG_LENGTH  = 1'b1
    } t_cfg_index;

    // one search result
    typedef struct packed {
        logic                found;
        logic [OUT_BITS-1:0] first_start;
        logic [OUT_BITS-1:0] last_start;
        logic [OUT_BITS-1:0] match_count;
        logic                text_overflow;
    } t_result;

    // per-transaction control from the stream side to the tally
    typedef struct packed {
        logic char_acc;
        logic end_acc;
        logic hit;
    } t_tally_ctl;

    // pattern length in effect: zero acts as one, large values clamp
    function automatic logic [LEN_BITS-1:0] used_length(input logic [LEN_BITS-1:0] len);
        logic [LEN_BITS-1:0] res;
        if (len == '0) begin
            res = LEN_BITS'(1);
        end else if (int'(len) > PATTERN_MAX) begin
            res = LEN_BITS'(PATTERN_MAX);
        end else begin
            res = len;
        end
        return res;
    endfunction

    // pattern byte that window cell j is compared against
    function automatic logic [CHAR_BITS-1:0] cell_pattern(input logic [PAT_BITS-1:0] pat,
                                                          input logic [LEN_BITS-1:0] used,
                                                          input int j);
        int k;
        logic [PAT_SEL_W-1:0] sel;
        k = int'(used) - 1 - j;
        sel = PAT_SEL_W'(k);
        if (k < 0) begin
            return '0;
        end
        return pat[{sel, 3'b000} +: CHAR_BITS];
    endfunction

endpackage

// File: sv/ssm_cell.sv
// one window cell: holds a character and compares its incoming one
`timescale 1ns / 1ps
module ssm_cell import ssm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  logic                 i_clear,
    input  logic [CHAR_BITS-1:0] i_byte,
    input  logic [CHAR_BITS-1:0] i_pat_byte,
    input  logic                 i_active,
    output logic [CHAR_BITS-1:0] o_byte,
    output logic                 o_hit
);

    logic [CHAR_BITS-1:0] r_byte;
    logic [CHAR_BITS-1:0] n_byte;

    // shift in from the neighbor, clear at end of text
    always_comb begin
        n_byte = r_byte;
        if (i_clear) begin
            n_byte = '0;
        end else if (i_shift) begin
            n_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

    // compare the byte this cell will hold after the shift
    assign o_hit  = !i_active || (i_byte == i_pat_byte);
    assign o_byte = r_byte;

endmodule

// File: sv/ssm_tally.sv
// position counter and match bookkeeping of the substring matcher
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ssm_tally import ssm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_tally_ctl          i_ctl,
    input  logic [LEN_BITS-1:0] i_used_len,
    output t_result             o_result
);

    logic [POS_BITS-1:0] r_pos;
    logic [POS_BITS-1:0] n_pos;
    logic                r_sat;
    logic                n_sat;
    logic                r_any;
    logic                n_any;
    logic [OUT_BITS-1:0] r_first;
    logic [OUT_BITS-1:0] n_first;
    logic [OUT_BITS-1:0] r_last;
    logic [OUT_BITS-1:0] n_last;
    logic [OUT_BITS-1:0] r_count;
    logic [OUT_BITS-1:0] n_count;

    logic [POS_BITS:0]   pos_plus;
    logic                gate;
    logic                match;
    logic [CALC_W-1:0]   start_calc;
    logic [OUT_BITS-1:0] start;

    // a match counts once enough characters are in, or after saturation
    assign pos_plus   = {1'b0, r_pos} + (POS_BITS + 1)'(1);
    assign gate       = r_sat || (pos_plus >= (POS_BITS + 1)'(i_used_len));
    assign match      = i_ctl.char_acc && i_ctl.hit && gate;
    assign start_calc = CALC_W'(r_pos) + CALC_W'(1) - CALC_W'(i_used_len);
    assign start      = start_calc[OUT_BITS-1:0];

    // next state
    always_comb begin
        n_pos   = r_pos;
        n_sat   = r_sat;
        n_any   = r_any;
        n_first = r_first;
        n_last  = r_last;
        n_count = r_count;
        if (i_ctl.end_acc) begin
            n_pos   = '0;
            n_sat   = 1'b0;
            n_any   = 1'b0;
            n_first = '0;
            n_last  = '0;
            n_count = '0;
        end else if (i_ctl.char_acc) begin
            if (match) begin
                if (!r_any) begin
                    n_first = start;
                end
                n_last = start;
                n_any  = 1'b1;
                if (r_count != COUNT_MAX) begin
                    n_count = r_count + OUT_BITS'(1);
                end else begin
                    n_sat = 1'b1;
                end
            end
            if (r_pos == POS_LIMIT) begin
                n_sat = 1'b1;
            end else begin
                n_pos = r_pos + POS_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_sat   <= 1'b0;
            r_any   <= 1'b0;
            r_first <= '0;
            r_last  <= '0;
            r_count <= '0;
        end else begin
            r_pos   <= n_pos;
            r_sat   <= n_sat;
            r_any   <= n_any;
            r_first <= n_first;
            r_last  <= n_last;
            r_count <= n_count;
        end
    end

    // report the state as it stands before the end marker clears it
    assign o_result.found         = r_any;
    assign o_result.first_start   = r_first;
    assign o_result.last_start    = r_last;
    assign o_result.match_count   = r_count;
    assign o_result.text_overflow = r_sat;

    // checks
    `SSM_ASSERT(a_clear_after_end, i_ctl.end_acc |=> (r_count == '0 && !r_any && !r_sat && r_pos == '0), "text state not cleared after end marker")
    `SSM_ASSERT(a_any_tracks_count, r_any == (r_count != '0), "found flag and count disagree")

endmodule

// File: sv/stream_substring_matcher_unit.sv
// top level of the streaming substring matcher
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
// Text enters on the slave stream, one character per transaction in tdata;
// a transaction with tlast high is the end marker and its tdata is ignored.
// The pattern (up to 8 bytes, first byte lowest) and its length are set
// through the write port: index 0 pattern bytes, index 1 pattern length.
// Write them only while no text is in flight.
// Each character shifts through a row of 8 window cells; all cells compare
// against the pattern in the same cycle, so one character is taken per clock while tready is high.
// On the end marker one result is registered into the output buffer for the master stream:
// found, first and last match start, overlapping match count, overflow flag.
// The text state then clears and the next text may follow at once.
// A two-entry output buffer lets input continue while a result waits;
// tready drops whenever two results are pending.
// Reset (synchronous, active low) clears the text state, the output buffer,
// and sets the pattern to zero with length one.
module stream_substring_matcher_unit import ssm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream: tdata = text_char[7:0]; tlast = end_marker
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0] i_s_axis_tdata,
    input  logic                  i_s_axis_tlast,
    // master stream: tdata = found[0], first_start[16:1], last_start[32:17],
    // match_count[48:33], text_overflow[49], zero pad above
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [TDATA_W-1:0]    o_m_axis_tdata,
    // configuration write port
    input  logic                  i_cfg_we,
    input  t_cfg_index            i_cfg_index,
    input  logic [PAT_BITS-1:0]   i_cfg_data
);

    logic [PAT_BITS-1:0] r_pattern;
    logic [LEN_BITS-1:0] r_length;

    logic                in_acc;
    logic                char_acc;
    logic                end_acc;
    logic [LEN_BITS-1:0] used_len;

    logic [CHAR_BITS-1:0] cell_in  [PATTERN_MAX];
    logic [CHAR_BITS-1:0] cell_out [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] cell_hit;

    t_tally_ctl          tally_ctl;
    t_result             tally_res;

    logic                r_out_valid;
    t_result             r_out_data;
    logic                r_skid_valid;
    t_result             r_skid_data;
    logic                pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_length  <= LEN_BITS'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PATTERN: r_pattern <= i_cfg_data;
                CFG_LENGTH:  r_length  <= i_cfg_data[LEN_BITS-1:0];
                default:     r_length  <= r_length;
            endcase
        end
    end

    assign used_len = used_length(r_length);

    // input handshake
    assign o_s_axis_tready = !r_skid_valid;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign char_acc        = in_acc && !i_s_axis_tlast;
    assign end_acc         = in_acc && i_s_axis_tlast;

    // row of window cells, newest character in cell 0
    genvar j;
    generate
        for (j = 0; j < PATTERN_MAX; j++) begin : g_cell
            if (j == 0) begin : g_head
                assign cell_in[j] = i_s_axis_tdata[CHAR_BITS-1:0];
            end else begin : g_link
                assign cell_in[j] = cell_out[j-1];
            end
            ssm_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_shift    (char_acc),
                .i_clear    (end_acc),
                .i_byte     (cell_in[j]),
                .i_pat_byte (cell_pattern(r_pattern, used_len, j)),
                .i_active   (int'(used_len) > j),
                .o_byte     (cell_out[j]),
                .o_hit      (cell_hit[j])
            );
        end
    endgenerate

    // match bookkeeping
    assign tally_ctl.char_acc = char_acc;
    assign tally_ctl.end_acc  = end_acc;
    assign tally_ctl.hit      = &cell_hit;

    ssm_tally u_tally (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (tally_ctl),
        .i_used_len (used_len),
        .o_result   (tally_res)
    );

    // two-entry output buffer
    assign pop = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= end_acc;
            end else begin
                r_out_valid <= end_acc;
            end
        end else if (end_acc) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
                if (end_acc) begin
                    r_skid_data <= tally_res;
                end
            end else if (end_acc) begin
                r_out_data <= tally_res;
            end
        end else if (end_acc) begin
            if (r_out_valid) begin
                r_skid_data <= tally_res;
            end else begin
                r_out_data <= tally_res;
            end
        end
    end

    // output stream
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{TDATA_PAD{1'b0}},
                              r_out_data.text_overflow,
                              r_out_data.match_count,
                              r_out_data.last_start,
                              r_out_data.first_start,
                              r_out_data.found};

    // checks
    `SSM_ASSERT(a_skid_needs_head, r_skid_valid |-> r_out_valid, "skid entry without head entry")
    `SSM_ASSERT(a_end_lands, (end_acc && !r_out_valid) |=> o_m_axis_tvalid, "end marker produced no result")

endmodule
